/* rtl/s2c_pkg.sv */
// shared types, constants and arctangent table for the spherical to cartesian converter
`timescale 1ns / 1ps

package s2c_pkg;

	// number of cordic micro-rotations, capped by the arctangent table length
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_LEN      = 24;
	localparam int CORDIC_STEPS  = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

	// q30 constants
	localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
	localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;

	// atan(2^-i) in degrees, q24
	localparam logic signed [31:0] ATAN_Q24 [ATAN_LEN] = '{
		32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
		32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
		32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
		32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
		32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
		32'sd917,       32'sd458,       32'sd229,       32'sd115
	};

	// one cordic lane: x is cos, y is sin, z is residual angle (q24 degrees)
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} s2c_lane_t;

	// fields that ride alongside the angle lanes
	typedef struct packed {
		logic [15:0] rng;
		logic        last;
		logic        negc_el;
		logic        negc_az;
	} s2c_side_t;

endpackage

/* rtl/s2c_fold.sv */
// input stage: wraps both angles into one turn, folds them into +-90 degrees, scales to q24
`timescale 1ns / 1ps

module s2c_fold (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [15:0]             range_in,
	input  logic signed [14:0]      elevation_deg,
	input  logic signed [15:0]      azimuth_deg,
	input  logic                    last_point,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [31:0]      out_z_el,
	output logic signed [31:0]      out_z_az,
	output s2c_pkg::s2c_side_t      out_side
);

	localparam logic signed [17:0] ANG_HALF = 18'sd23040;
	localparam logic signed [17:0] ANG_FULL = 18'sd46080;
	localparam logic signed [17:0] ANG_QTR  = 18'sd11520;

	typedef struct packed {
		logic               negc;
		logic signed [14:0] ang;
	} fold_t;

	function automatic fold_t fold_angle(input logic signed [16:0] a);
		logic signed [17:0] w;
		logic signed [17:0] f;
		fold_t              r;
		w = 18'(a);
		if (w >= ANG_HALF) begin
			w = w - ANG_FULL;
		end else if (w < -ANG_HALF) begin
			w = w + ANG_FULL;
		end
		r.negc = 1'b1;
		if (w > ANG_QTR) begin
			f = ANG_HALF - w;
		end else if (w < -ANG_QTR) begin
			f = -ANG_HALF - w;
		end else begin
			f      = w;
			r.negc = 1'b0;
		end
		r.ang = f[14:0];
		return r;
	endfunction

	fold_t              el_f;
	fold_t              az_f;
	logic               valid_s1;
	logic signed [31:0] z_el_s1;
	logic signed [31:0] z_az_s1;
	s2c_pkg::s2c_side_t side_s1;

	assign el_f = fold_angle(17'(elevation_deg));
	assign az_f = fold_angle(17'(azimuth_deg));

	assign in_ready = ~valid_s1 | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			// times 2^17 takes q7 degrees to q24
			z_el_s1         <= $signed({el_f.ang, 17'b0});
			z_az_s1         <= $signed({az_f.ang, 17'b0});
			side_s1.rng     <= range_in;
			side_s1.last    <= last_point;
			side_s1.negc_el <= el_f.negc;
			side_s1.negc_az <= az_f.negc;
		end
	end

	assign out_valid = valid_s1;
	assign out_z_el  = z_el_s1;
	assign out_z_az  = z_az_s1;
	assign out_side  = side_s1;

endmodule

/* rtl/s2c_cordic.sv */
// dual-lane pipelined rotation cordic, one micro-rotation per register stage
`timescale 1ns / 1ps

module s2c_cordic (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [31:0]      in_z_el,
	input  logic signed [31:0]      in_z_az,
	input  s2c_pkg::s2c_side_t      in_side,
	output logic                    out_valid,
	input  logic                    out_ready,
	output s2c_pkg::s2c_lane_t      out_el,
	output s2c_pkg::s2c_lane_t      out_az,
	output s2c_pkg::s2c_side_t      out_side
);

	localparam int STEPS = s2c_pkg::CORDIC_STEPS;

	function automatic s2c_pkg::s2c_lane_t rotate(
		input s2c_pkg::s2c_lane_t a,
		input int                 sh,
		input logic signed [31:0] ang
	);
		s2c_pkg::s2c_lane_t r;
		logic signed [31:0] xs;
		logic signed [31:0] ys;
		xs = $signed(a.x) >>> sh;
		ys = $signed(a.y) >>> sh;
		if (a.z[31]) begin
			r.x = a.x + ys;
			r.y = a.y - xs;
			r.z = a.z + ang;
		end else begin
			r.x = a.x - ys;
			r.y = a.y + xs;
			r.z = a.z - ang;
		end
		return r;
	endfunction

	s2c_pkg::s2c_lane_t el_s   [STEPS];
	s2c_pkg::s2c_lane_t az_s   [STEPS];
	s2c_pkg::s2c_side_t side_s [STEPS];
	logic               valid_s [STEPS];
	wire  [STEPS:0]     ld;

	assign ld[STEPS] = out_ready;
	assign in_ready  = ld[0];

	for (genvar k = 0; k < STEPS; k++) begin : g_stage
		s2c_pkg::s2c_lane_t el_d;
		s2c_pkg::s2c_lane_t az_d;
		s2c_pkg::s2c_side_t side_d;
		logic               vld_d;

		if (k == 0) begin : g_first
			assign el_d   = '{x: s2c_pkg::GAIN_Q30, y: '0, z: in_z_el};
			assign az_d   = '{x: s2c_pkg::GAIN_Q30, y: '0, z: in_z_az};
			assign side_d = in_side;
			assign vld_d  = in_valid;
		end else begin : g_next
			assign el_d   = el_s[k-1];
			assign az_d   = az_s[k-1];
			assign side_d = side_s[k-1];
			assign vld_d  = valid_s[k-1];
		end

		// a stage loads when empty or when the next one moves on
		assign ld[k] = ~valid_s[k] | ld[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (ld[k]) begin
				valid_s[k] <= vld_d;
			end
		end

		always_ff @(posedge clk) begin
			if (ld[k]) begin
				el_s[k]   <= rotate(el_d, k, s2c_pkg::ATAN_Q24[k]);
				az_s[k]   <= rotate(az_d, k, s2c_pkg::ATAN_Q24[k]);
				side_s[k] <= side_d;
			end
		end
	end

	assign out_valid = valid_s[STEPS-1];
	assign out_el    = el_s[STEPS-1];
	assign out_az    = az_s[STEPS-1];
	assign out_side  = side_s[STEPS-1];

endmodule

/* rtl/s2c_scale.sv */
// clamp, two rounds of magnitude multiply with rounding, sign attach and output register
`timescale 1ns / 1ps

module s2c_scale (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  s2c_pkg::s2c_lane_t      in_el,
	input  s2c_pkg::s2c_lane_t      in_az,
	input  s2c_pkg::s2c_side_t      in_side,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [16:0]      x_out,
	output logic signed [16:0]      y_out,
	output logic signed [16:0]      z_out,
	output logic                    last_out
);

	function automatic logic [30:0] clamp_mag(input logic signed [31:0] v);
		logic [30:0] m;
		if (v > s2c_pkg::ONE_Q30 || v < -s2c_pkg::ONE_Q30) begin
			m = s2c_pkg::ONE_Q30[30:0];
		end else if (v[31]) begin
			m = 31'(-v);
		end else begin
			m = v[30:0];
		end
		return m;
	endfunction

	// (p + 2^29) >> 30, never above the 16 bit factor
	function automatic logic [15:0] round_q30(input logic [46:0] p);
		return p[45:30] + {15'b0, p[29]};
	endfunction

	function automatic logic signed [16:0] apply_sign(input logic [15:0] m, input logic neg);
		logic signed [16:0] s;
		s = $signed({1'b0, m});
		return neg ? -s : s;
	endfunction

	logic       valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	wire  [5:0] ld;

	// stage 1: clamp and magnitudes
	logic [30:0]        ce_mag_s1, se_mag_s1, ca_mag_s1, sa_mag_s1;
	logic               ce_neg_s1, se_neg_s1, ca_neg_s1, sa_neg_s1;
	logic [15:0]        rng_s1;
	logic               last_s1;
	// stage 2: range times elevation terms
	logic [46:0]        prc_s2, pz_s2;
	logic [30:0]        ca_mag_s2, sa_mag_s2;
	logic               ce_neg_s2, se_neg_s2, ca_neg_s2, sa_neg_s2;
	logic               last_s2;
	// stage 3: first rounding
	logic [15:0]        rc_s3;
	logic signed [16:0] z_s3;
	logic [30:0]        ca_mag_s3, sa_mag_s3;
	logic               xneg_s3, yneg_s3;
	logic               last_s3;
	// stage 4: horizontal range times azimuth terms
	logic [46:0]        px_s4, py_s4;
	logic signed [16:0] z_s4;
	logic               xneg_s4, yneg_s4;
	logic               last_s4;
	// stage 5: output register
	logic signed [16:0] x_s5, y_s5, z_s5;
	logic               last_s5;

	assign ld[5]    = out_ready;
	assign ld[4]    = ~valid_s5 | ld[5];
	assign ld[3]    = ~valid_s4 | ld[4];
	assign ld[2]    = ~valid_s3 | ld[3];
	assign ld[1]    = ~valid_s2 | ld[2];
	assign ld[0]    = ~valid_s1 | ld[1];
	assign in_ready = ld[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ld[0]) valid_s1 <= in_valid;
			if (ld[1]) valid_s2 <= valid_s1;
			if (ld[2]) valid_s3 <= valid_s2;
			if (ld[3]) valid_s4 <= valid_s3;
			if (ld[4]) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			ce_mag_s1 <= clamp_mag(in_el.x);
			se_mag_s1 <= clamp_mag(in_el.y);
			ca_mag_s1 <= clamp_mag(in_az.x);
			sa_mag_s1 <= clamp_mag(in_az.y);
			// folded angles flip the cosine sign
			ce_neg_s1 <= in_side.negc_el ^ in_el.x[31];
			se_neg_s1 <= in_el.y[31];
			ca_neg_s1 <= in_side.negc_az ^ in_az.x[31];
			sa_neg_s1 <= in_az.y[31];
			rng_s1    <= in_side.rng;
			last_s1   <= in_side.last;
		end
		if (ld[1]) begin
			prc_s2    <= {31'b0, rng_s1} * {16'b0, ce_mag_s1};
			pz_s2     <= {31'b0, rng_s1} * {16'b0, se_mag_s1};
			ca_mag_s2 <= ca_mag_s1;
			sa_mag_s2 <= sa_mag_s1;
			ce_neg_s2 <= ce_neg_s1;
			se_neg_s2 <= se_neg_s1;
			ca_neg_s2 <= ca_neg_s1;
			sa_neg_s2 <= sa_neg_s1;
			last_s2   <= last_s1;
		end
		if (ld[2]) begin
			rc_s3     <= round_q30(prc_s2);
			z_s3      <= apply_sign(round_q30(pz_s2), se_neg_s2);
			ca_mag_s3 <= ca_mag_s2;
			sa_mag_s3 <= sa_mag_s2;
			xneg_s3   <= ce_neg_s2 ^ ca_neg_s2;
			yneg_s3   <= ce_neg_s2 ^ sa_neg_s2;
			last_s3   <= last_s2;
		end
		if (ld[3]) begin
			px_s4   <= {31'b0, rc_s3} * {16'b0, ca_mag_s3};
			py_s4   <= {31'b0, rc_s3} * {16'b0, sa_mag_s3};
			z_s4    <= z_s3;
			xneg_s4 <= xneg_s3;
			yneg_s4 <= yneg_s3;
			last_s4 <= last_s3;
		end
		if (ld[4]) begin
			x_s5    <= apply_sign(round_q30(px_s4), xneg_s4);
			y_s5    <= apply_sign(round_q30(py_s4), yneg_s4);
			z_s5    <= z_s4;
			last_s5 <= last_s4;
		end
	end

	assign out_valid = valid_s5;
	assign x_out     = x_s5;
	assign y_out     = y_s5;
	assign z_out     = z_s5;
	assign last_out  = last_s5;

endmodule

/* rtl/spherical_to_cartesian.sv */
// top level of the radar detection spherical to cartesian converter
`timescale 1ns / 1ps

// converts one radar detection (range, elevation, azimuth in q7 degrees) per
// transaction into cartesian x, y, z in units of 1/256 metre
// detection channel: det_valid / det_ready with range_in, elevation_deg,
// azimuth_deg and last_point; result channel: xyz_valid / xyz_ready with
// x_out, y_out, z_out and last_out, last_out copying last_point
// throughput: one transaction per cycle unless xyz_ready stalls the pipe,
// every stage is a register slice; stages: one fold stage, one cordic
// stage per micro-rotation, then clamp, multiply, round, multiply and the
// output register
// each stage loads when it is empty or when the stage after it moves, so
// bubbles close up and a new transaction is taken while a finished result
// waits on a stalled receiver; det_ready drops only once every stage holds
// a transaction, and nothing is lost or repeated under a stall
// reset (arst_n low) empties all stages; no configuration and no state
// beyond the pipeline, so results depend on their own transaction only

module spherical_to_cartesian (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               det_valid,
	output logic               det_ready,
	input  logic [15:0]        range_in,
	input  logic signed [14:0] elevation_deg,
	input  logic signed [15:0] azimuth_deg,
	input  logic               last_point,
	output logic               xyz_valid,
	input  logic               xyz_ready,
	output logic signed [16:0] x_out,
	output logic signed [16:0] y_out,
	output logic signed [16:0] z_out,
	output logic               last_out
);

	// fold stage to cordic
	logic               fold_valid;
	logic               fold_ready;
	logic signed [31:0] fold_z_el;
	logic signed [31:0] fold_z_az;
	s2c_pkg::s2c_side_t fold_side;

	// cordic to scaling
	logic               cord_valid;
	logic               cord_ready;
	s2c_pkg::s2c_lane_t cord_el;
	s2c_pkg::s2c_lane_t cord_az;
	s2c_pkg::s2c_side_t cord_side;

	// wrap and fold angles, scale to q24
	s2c_fold u_fold (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (det_valid),
		.in_ready      (det_ready),
		.range_in      (range_in),
		.elevation_deg (elevation_deg),
		.azimuth_deg   (azimuth_deg),
		.last_point    (last_point),
		.out_valid     (fold_valid),
		.out_ready     (fold_ready),
		.out_z_el      (fold_z_el),
		.out_z_az      (fold_z_az),
		.out_side      (fold_side)
	);

	// sine and cosine of both angles side by side
	s2c_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fold_valid),
		.in_ready  (fold_ready),
		.in_z_el   (fold_z_el),
		.in_z_az   (fold_z_az),
		.in_side   (fold_side),
		.out_valid (cord_valid),
		.out_ready (cord_ready),
		.out_el    (cord_el),
		.out_az    (cord_az),
		.out_side  (cord_side)
	);

	// r*cos(el) first, then the azimuth terms; z straight from r*sin(el)
	s2c_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cord_valid),
		.in_ready  (cord_ready),
		.in_el     (cord_el),
		.in_az     (cord_az),
		.in_side   (cord_side),
		.out_valid (xyz_valid),
		.out_ready (xyz_ready),
		.x_out     (x_out),
		.y_out     (y_out),
		.z_out     (z_out),
		.last_out  (last_out)
	);

endmodule

/* rtl/s2c_checker.sv */
// port-level assertions for the spherical to cartesian converter, bound to the top level
`timescale 1ns / 1ps

module s2c_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               det_ready,
	input logic               xyz_valid,
	input logic               xyz_ready,
	input logic signed [16:0] x_out,
	input logic signed [16:0] y_out,
	input logic signed [16:0] z_out,
	input logic               last_out
);

	// a stalled result stays offered
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		xyz_valid && !xyz_ready |=> xyz_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		xyz_valid && !xyz_ready |=> $stable(x_out) && $stable(y_out) &&
			$stable(z_out) && $stable(last_out))
		else $error("result payload changed while stalled");

	// with the output register empty every stage can move, so input is open
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!xyz_valid |-> det_ready)
		else $error("detection channel blocked with empty output");

	// magnitudes never exceed the range, so the most negative code never shows
	a_no_min_code: assert property (@(posedge clk) disable iff (!arst_n)
		xyz_valid |-> x_out != 17'h10000 && y_out != 17'h10000 && z_out != 17'h10000)
		else $error("coordinate magnitude beyond range");

endmodule

bind spherical_to_cartesian s2c_checker u_s2c_checker (.*);
